/* src/pgn_pkg.sv */
// ----------------------------------------------------------------------------
// pgn_pkg
// shared types, codes and defaults of the 2d gradient noise core
// ----------------------------------------------------------------------------
package pgn_pkg;

  localparam int GRID_W_MAX_DFLT = 64;
  localparam int GRID_H_MAX_DFLT = 64;
  localparam int COORD_BITS_DFLT = 16;
  localparam int FRAC_BITS_DFLT  = 16;

  localparam int GRAD_W     = 16;
  localparam int SCALE_W    = 24;
  localparam int SIZE_W     = 7;
  localparam int CELL_IDX_W = 6;
  localparam int NOISE_W    = 16;
  localparam int DOT_W      = GRAD_W + 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam int FADE_6  = 6;
  localparam int FADE_15 = 15;
  localparam int FADE_10 = 10;

  localparam logic [SIZE_W-1:0]  GRID_SIZE_RST = SIZE_W'(64);
  localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(65536);

  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sd16384;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = -16'sd16384;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 4'd0,
    CFG_GRID_HEIGHT = 4'd1,
    CFG_SCALE_X     = 4'd2,
    CFG_SCALE_Y     = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gx;
  } grad_t;

  typedef struct packed {
    logic valid;
    logic eval;
    logic oor;
  } tag_t;

endpackage

/* src/pgn_grad_bank.sv */
// ----------------------------------------------------------------------------
// pgn_grad_bank
// one gradient bank: single write port, single registered read port
// ----------------------------------------------------------------------------
module pgn_grad_bank
  import pgn_pkg::*;
#(
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  grad_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output grad_t             rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  grad_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pgn_fade.sv */
// ----------------------------------------------------------------------------
// pgn_fade
// three stage fade curve 6t^5 - 15t^4 + 10t^3, rounded at each product
// ----------------------------------------------------------------------------
module pgn_fade
  import pgn_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
  input  logic                 clk,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FRAC_BITS:0]   u
);

  localparam int F = FRAC_BITS;

  localparam logic [2*F-1:0]   HALF_SQ     = (2*F)'(1) << (F-1);
  localparam logic [2*F+5:0]   HALF_WIDE   = (2*F+6)'(1) << (F-1);
  localparam logic [F+4:0]     FIFTEEN_ONE = (F+5)'(FADE_15) << F;
  localparam logic [F+4:0]     TEN_ONE     = (F+5)'(FADE_10) << F;
  localparam logic [F+5:0]     ONE_WIDE    = (F+6)'(1) << F;

  // stage a: t^2 and t*(6t-15)
  logic [2*F-1:0]        tt;
  logic [2*F-1:0]        tt_rnd;
  logic signed [F+4:0]   lin;
  logic signed [2*F+5:0] tl;
  logic signed [2*F+5:0] tl_rnd;

  logic [F-1:0]          t_b;
  logic [F-1:0]          t2_b;
  logic signed [F+4:0]   q_b;

  assign tt     = t * t;
  assign tt_rnd = tt + HALF_SQ;
  assign lin    = (F+5)'(t) * (F+5)'(FADE_6) - FIFTEEN_ONE;
  assign tl     = $signed({1'b0, t}) * lin;
  assign tl_rnd = tl + HALF_WIDE;

  always_ff @(posedge clk) begin
    t_b  <= t;
    t2_b <= tt_rnd[2*F-1:F];
    q_b  <= tl_rnd[2*F+4:F];
  end

  // stage b: t^3 and the horner sum
  logic [2*F-1:0]      t3p;
  logic [2*F-1:0]      t3p_rnd;
  logic [F-1:0]        t3_c;
  logic signed [F+4:0] p_c;

  assign t3p     = t2_b * t_b;
  assign t3p_rnd = t3p + HALF_SQ;

  always_ff @(posedge clk) begin
    t3_c <= t3p_rnd[2*F-1:F];
    p_c  <= q_b + TEN_ONE;
  end

  // stage c: final product and clamp to [0, 1]
  logic signed [2*F+5:0] pt;
  logic signed [2*F+5:0] pt_rnd;
  logic signed [F+5:0]   ur;
  logic [F:0]            u_next;

  assign pt     = p_c * $signed({1'b0, t3_c});
  assign pt_rnd = pt + HALF_WIDE;
  assign ur     = pt_rnd[2*F+5:F];

  always_comb begin
    if (ur < 0) begin
      u_next = '0;
    end else if (ur > $signed(ONE_WIDE)) begin
      u_next = ONE_WIDE[F:0];
    end else begin
      u_next = ur[F:0];
    end
  end

  always_ff @(posedge clk) begin
    u <= u_next;
  end

endmodule

/* src/pgn_interp.sv */
// ----------------------------------------------------------------------------
// pgn_interp
// corner dot products and the two step bilinear blend, saturated to q1.14
// ----------------------------------------------------------------------------
module pgn_interp
  import pgn_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
  input  logic                       clk,
  input  grad_t                      grad [4],
  input  logic [FRAC_BITS-1:0]       fx,
  input  logic [FRAC_BITS-1:0]       fy,
  input  logic [FRAC_BITS:0]         u,
  input  logic [FRAC_BITS:0]         v,
  output logic signed [NOISE_W-1:0]  noise
);

  localparam int F  = FRAC_BITS;
  localparam int PW = GRAD_W + F + 1;
  localparam int SW = PW + 1;
  localparam int YW = DOT_W + F + 3;

  localparam logic [SW-1:0] HALF_D = SW'(1) << (F-1);
  localparam logic [YW-1:0] HALF_L = YW'(1) << (F-1);

  // corner order: c00, c01 (y+1), c10 (x+1), c11
  logic signed [F:0] dx0, dx1, dy0, dy1;

  assign dx0 = {1'b0, fx};
  assign dx1 = {1'b1, fx};
  assign dy0 = {1'b0, fy};
  assign dy1 = {1'b1, fy};

  logic signed [PW-1:0] pgx [4];
  logic signed [PW-1:0] pgy [4];

  always_ff @(posedge clk) begin
    pgx[0] <= $signed(grad[0].gx) * dx0;
    pgy[0] <= $signed(grad[0].gy) * dy0;
    pgx[1] <= $signed(grad[1].gx) * dx0;
    pgy[1] <= $signed(grad[1].gy) * dy1;
    pgx[2] <= $signed(grad[2].gx) * dx1;
    pgy[2] <= $signed(grad[2].gy) * dy0;
    pgx[3] <= $signed(grad[3].gx) * dx1;
    pgy[3] <= $signed(grad[3].gy) * dy1;
  end

  logic signed [SW-1:0]    dsum [4];
  logic signed [SW-1:0]    dsum_rnd [4];
  logic signed [DOT_W-1:0] dot [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dsum[k]     = pgx[k] + pgy[k];
      dsum_rnd[k] = dsum[k] + HALF_D;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      dot[k] <= dsum_rnd[k][F+DOT_W-1:F];
    end
  end

  // blend along y with v
  logic signed [DOT_W:0]   dify [2];
  logic signed [YW-1:0]    prody [2];
  logic signed [DOT_W-1:0] base_y [2];
  logic [F:0]              u_d1;

  assign dify[0] = dot[1] - dot[0];
  assign dify[1] = dot[3] - dot[2];

  always_ff @(posedge clk) begin
    prody[0]  <= dify[0] * $signed({1'b0, v});
    prody[1]  <= dify[1] * $signed({1'b0, v});
    base_y[0] <= dot[0];
    base_y[1] <= dot[2];
    u_d1      <= u;
  end

  logic signed [YW-1:0]    prody_rnd [2];
  logic signed [DOT_W:0]   stepy [2];
  logic signed [DOT_W:0]   lysum [2];
  logic signed [DOT_W-1:0] ly [2];
  logic [F:0]              u_d2;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      prody_rnd[j] = prody[j] + HALF_L;
      stepy[j]     = prody_rnd[j][F+DOT_W:F];
      lysum[j]     = base_y[j] + stepy[j];
    end
  end

  always_ff @(posedge clk) begin
    ly[0] <= lysum[0][DOT_W-1:0];
    ly[1] <= lysum[1][DOT_W-1:0];
    u_d2  <= u_d1;
  end

  // blend along x with u
  logic signed [DOT_W:0]   difx;
  logic signed [YW-1:0]    prodx;
  logic signed [DOT_W-1:0] base_x;

  assign difx = ly[1] - ly[0];

  always_ff @(posedge clk) begin
    prodx  <= difx * $signed({1'b0, u_d2});
    base_x <= ly[0];
  end

  logic signed [YW-1:0]  prodx_rnd;
  logic signed [DOT_W:0] stepx;
  logic signed [DOT_W:0] nsum;

  assign prodx_rnd = prodx + HALF_L;
  assign stepx     = prodx_rnd[F+DOT_W:F];
  assign nsum      = base_x + stepx;

  always_comb begin
    if (nsum > NOISE_MAX) begin
      noise = NOISE_MAX;
    end else if (nsum < NOISE_MIN) begin
      noise = NOISE_MIN;
    end else begin
      noise = nsum[NOISE_W-1:0];
    end
  end

endmodule

/* src/pgn_out_fifo.sv */
// ----------------------------------------------------------------------------
// pgn_out_fifo
// small result queue between the pipeline and the output channel
// ----------------------------------------------------------------------------
module pgn_out_fifo
  import pgn_pkg::*;
#(
  parameter int DEPTH = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic signed [NOISE_W-1:0] push_noise,
  input  logic                      push_oor,
  input  logic                      pop,
  output logic                      valid,
  output logic signed [NOISE_W-1:0] noise,
  output logic                      oor
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [NOISE_W-1:0] noise_mem [DEPTH];
  logic                      oor_mem [DEPTH];
  logic [PTR_W-1:0]          head, head_next;
  logic [PTR_W-1:0]          tail, tail_next;
  logic [CNT_W-1:0]          count;

  assign head_next = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail_next;
      end
      if (pop) begin
        head <= head_next;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      noise_mem[tail] <= push_noise;
      oor_mem[tail]   <= push_oor;
    end
  end

  assign valid = (count != '0);
  assign noise = noise_mem[head];
  assign oor   = oor_mem[head];

endmodule

/* src/perlin_gradient_noise_2d_core.sv */
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d_core
// 2d gradient noise over a banked gradient memory, one sample per unstalled cycle
// ----------------------------------------------------------------------------
//  channel | handshake              | beat contents
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | req_type, grid_col/row, grad_x/y, sample_x/y
//  out     | out_valid / out_stall  | noise_value, out_of_range
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one beat per cycle in and out unless stalled; results leave in beat order
//  the four corner reads are served by four parity banks, one read port each
//  a credit count over pipeline and result queue raises in_stall when full
//  rst clears control, the queue and the cfg registers; the gradient memory is not
//  cleared, so every cell used by an evaluate beat must have been written
// ----------------------------------------------------------------------------
module perlin_gradient_noise_2d_core
  import pgn_pkg::*;
#(
  parameter int GRID_W_MAX = GRID_W_MAX_DFLT,
  parameter int GRID_H_MAX = GRID_H_MAX_DFLT,
  parameter int COORD_BITS = COORD_BITS_DFLT,
  parameter int FRAC_BITS  = FRAC_BITS_DFLT
) (
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      req_type,
  input  logic [CELL_IDX_W-1:0]     grid_col,
  input  logic [CELL_IDX_W-1:0]     grid_row,
  input  logic signed [GRAD_W-1:0]  grad_x,
  input  logic signed [GRAD_W-1:0]  grad_y,
  input  logic [COORD_BITS-1:0]     sample_x,
  input  logic [COORD_BITS-1:0]     sample_y,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [NOISE_W-1:0] noise_value,
  output logic                      out_of_range,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int F        = FRAC_BITS;
  localparam int PROD_W   = COORD_BITS + SCALE_W;
  localparam int CXW      = PROD_W - F;
  localparam int HCB      = ($clog2(GRID_W_MAX) > 1) ? $clog2(GRID_W_MAX) - 1 : 1;
  localparam int HRB      = ($clog2(GRID_H_MAX) > 1) ? $clog2(GRID_H_MAX) - 1 : 1;
  localparam int BANK_AW  = HCB + HRB;
  localparam int PIPE_LEN = 7;
  localparam int CAP      = PIPE_LEN + 2;
  localparam int CRED_W   = $clog2(CAP + 1);

  // configuration registers
  logic [SIZE_W-1:0]  grid_width;
  logic [SIZE_W-1:0]  grid_height;
  logic [SCALE_W-1:0] scale_x;
  logic [SCALE_W-1:0] scale_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIZE_RST;
      grid_height <= GRID_SIZE_RST;
      scale_x     <= SCALE_RST;
      scale_y     <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[SIZE_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[SIZE_W-1:0];
        CFG_SCALE_X:     scale_x     <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_Y:     scale_y     <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [SIZE_W-1:0] gw_eff;
  logic [SIZE_W-1:0] gh_eff;

  assign gw_eff = (32'(grid_width) > GRID_W_MAX) ? SIZE_W'(GRID_W_MAX) : grid_width;
  assign gh_eff = (32'(grid_height) > GRID_H_MAX) ? SIZE_W'(GRID_H_MAX) : grid_height;

  // input beat and credits
  logic              in_fire;
  logic              pop;
  logic [CRED_W-1:0] credits;

  assign in_stall = (credits == CRED_W'(CAP));
  assign in_fire  = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + CRED_W'(in_fire) - CRED_W'(pop);
    end
  end

  // gradient write at accept
  logic         wr_en;
  logic [1:0]   wr_bank;
  logic [BANK_AW-1:0] wr_addr;
  grad_t        wr_data;

  assign wr_en   = in_fire && (req_type == REQ_WRITE) &&
                   (32'(grid_col) < GRID_W_MAX) && (32'(grid_row) < GRID_H_MAX);
  assign wr_bank = {grid_row[0], grid_col[0]};
  assign wr_addr = {HRB'(grid_row >> 1), HCB'(grid_col >> 1)};
  assign wr_data = '{gy: grad_y, gx: grad_x};

  // stage 1: scaled coordinates
  tag_t              tag_pipe [PIPE_LEN];
  logic [PROD_W-1:0] px_s1;
  logic [PROD_W-1:0] py_s1;

  always_ff @(posedge clk) begin
    px_s1 <= PROD_W'(sample_x) * PROD_W'(scale_x);
    py_s1 <= PROD_W'(sample_y) * PROD_W'(scale_y);
  end

  logic [CXW-1:0] cx, cy;
  logic [CXW:0]   cx_inc, cy_inc;
  logic [F-1:0]   fx_s1, fy_s1;
  logic           oor_s1;

  assign cx     = px_s1[PROD_W-1:F];
  assign cy     = py_s1[PROD_W-1:F];
  assign fx_s1  = px_s1[F-1:0];
  assign fy_s1  = py_s1[F-1:0];
  assign cx_inc = {1'b0, cx} + (CXW+1)'(1);
  assign cy_inc = {1'b0, cy} + (CXW+1)'(1);
  assign oor_s1 = (cx_inc >= (CXW+1)'(gw_eff)) || (cy_inc >= (CXW+1)'(gh_eff));

  // bank read addresses: even parity bank takes the upper neighbor when odd
  logic [HCB-1:0]     ch_even, ch_odd;
  logic [HRB-1:0]     rh_even, rh_odd;
  logic [BANK_AW-1:0] rd_addr [4];

  assign ch_odd  = HCB'(cx >> 1);
  assign ch_even = HCB'(cx >> 1) + HCB'(cx[0]);
  assign rh_odd  = HRB'(cy >> 1);
  assign rh_even = HRB'(cy >> 1) + HRB'(cy[0]);

  assign rd_addr[0] = {rh_even, ch_even};
  assign rd_addr[1] = {rh_even, ch_odd};
  assign rd_addr[2] = {rh_odd,  ch_even};
  assign rd_addr[3] = {rh_odd,  ch_odd};

  grad_t bank_rdata [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    pgn_grad_bank #(
      .ADDR_W (BANK_AW)
    ) u_bank (
      .clk   (clk),
      .we    (wr_en && (wr_bank == 2'(b))),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr[b]),
      .rdata (bank_rdata[b])
    );
  end

  // stage 2: corner routing
  logic [F-1:0] fx_s2, fy_s2;
  logic         parx_s2, pary_s2;

  always_ff @(posedge clk) begin
    fx_s2   <= fx_s1;
    fy_s2   <= fy_s1;
    parx_s2 <= cx[0];
    pary_s2 <= cy[0];
  end

  grad_t corner [4];

  assign corner[0] = bank_rdata[{pary_s2,  parx_s2}];
  assign corner[1] = bank_rdata[{!pary_s2, parx_s2}];
  assign corner[2] = bank_rdata[{pary_s2,  !parx_s2}];
  assign corner[3] = bank_rdata[{!pary_s2, !parx_s2}];

  // fade units, u and v valid at stage 4
  logic [F:0] fade_u, fade_v;

  pgn_fade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fade_x (
    .clk (clk),
    .t   (fx_s1),
    .u   (fade_u)
  );

  pgn_fade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fade_y (
    .clk (clk),
    .t   (fy_s1),
    .u   (fade_v)
  );

  logic signed [NOISE_W-1:0] blend;

  pgn_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk   (clk),
    .grad  (corner),
    .fx    (fx_s2),
    .fy    (fy_s2),
    .u     (fade_u),
    .v     (fade_v),
    .noise (blend)
  );

  // beat tags alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LEN; i++) begin
        tag_pipe[i] <= '0;
      end
    end else begin
      tag_pipe[0] <= '{valid: in_fire, eval: (req_type == REQ_EVAL), oor: 1'b0};
      tag_pipe[1] <= '{valid: tag_pipe[0].valid, eval: tag_pipe[0].eval, oor: oor_s1};
      for (int i = 2; i < PIPE_LEN; i++) begin
        tag_pipe[i] <= tag_pipe[i-1];
      end
    end
  end

  tag_t                      tag_last;
  logic signed [NOISE_W-1:0] res_noise;
  logic                      res_oor;

  assign tag_last  = tag_pipe[PIPE_LEN-1];
  assign res_noise = (tag_last.eval && !tag_last.oor) ? blend : '0;
  assign res_oor   = tag_last.eval && tag_last.oor;

  pgn_out_fifo #(
    .DEPTH (CAP)
  ) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (tag_last.valid),
    .push_noise (res_noise),
    .push_oor   (res_oor),
    .pop        (pop),
    .valid      (out_valid),
    .noise      (noise_value),
    .oor        (out_of_range)
  );

endmodule

/* src/pgn_checker.sv */
// ----------------------------------------------------------------------------
// pgn_checker
// port level checks on the result channel of the noise core
// ----------------------------------------------------------------------------
module pgn_checker
  import pgn_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [NOISE_W-1:0] noise_value,
  input logic                      out_of_range
);

  // result queue is empty right after reset
  a_empty_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  a_held_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(noise_value) && $stable(out_of_range))
    else $error("stalled result beat changed");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> noise_value == '0)
    else $error("flagged cell with nonzero noise");

  a_noise_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (noise_value <= NOISE_MAX) && (noise_value >= NOISE_MIN))
    else $error("noise outside q1.14 unit range");

endmodule

bind perlin_gradient_noise_2d_core pgn_checker u_pgn_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .noise_value  (noise_value),
  .out_of_range (out_of_range)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// regression bench for the 2d gradient noise core: gradient writes and noise
// samples are driven under random idling on both channels, each accepted beat
// is run through a bit-exact fixed-point noise predictor, and every returned
// beat is compared with the oldest expected noise value and cell flag
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pgn_pkg::*;

  localparam int     GRID_W      = GRID_W_MAX_DFLT;
  localparam int     GRID_CELLS  = GRID_W_MAX_DFLT * GRID_H_MAX_DFLT;
  localparam int     FRAC        = FRAC_BITS_DFLT;
  localparam longint UNIT        = longint'(1) << FRAC_BITS_DFLT;
  localparam int     LATENCY     = 7;
  localparam int     HOLD_CYCLES = 300;
  localparam int     CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd9;

  typedef struct {
    req_type_t                kind;
    logic [CELL_IDX_W-1:0]    col;
    logic [CELL_IDX_W-1:0]    row;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [COORD_BITS_DFLT-1:0] sx;
    logic [COORD_BITS_DFLT-1:0] sy;
  } noise_req_t;

  typedef struct {
    logic signed [NOISE_W-1:0] value;
    logic                      flag;
  } noise_res_t;

  class noise_checker;
    logic [31:0]        grad_mem [GRID_CELLS];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [SCALE_W-1:0] scale_x_reg;
    logic [SCALE_W-1:0] scale_y_reg;
    noise_res_t         pending_noise [$];
    int                 mismatches;

    function new();
      foreach (grad_mem[i]) grad_mem[i] = '0;
      width_reg   = GRID_SIZE_RST;
      height_reg  = GRID_SIZE_RST;
      scale_x_reg = SCALE_RST;
      scale_y_reg = SCALE_RST;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:  width_reg = data[SIZE_W-1:0];
        CFG_GRID_HEIGHT: height_reg = data[SIZE_W-1:0];
        CFG_SCALE_X:     scale_x_reg = data[SCALE_W-1:0];
        CFG_SCALE_Y:     scale_y_reg = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint rnd(longint v);
      return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function longint fade(longint t);
      longint t2, t3, p, u;
      t2 = rnd(t * t);
      t3 = rnd(t2 * t);
      p = rnd(t * (FADE_6 * t - FADE_15 * UNIT)) + FADE_10 * UNIT;
      u = rnd(p * t3);
      if (u < 0) u = 0;
      if (u > UNIT) u = UNIT;
      return u;
    endfunction

    function longint lerp(longint w, longint a, longint b);
      return a + rnd(w * (b - a));
    endfunction

    function longint corner_dot(logic [31:0] entry, longint dx, longint dy);
      longint gx, gy;
      gx = longint'($signed(entry[15:0]));
      gy = longint'($signed(entry[31:16]));
      return rnd(gx * dx + gy * dy);
    endfunction

    // cell lookup under the current grid size and scales
    function bit locate_cell(input logic [COORD_BITS_DFLT-1:0] sx, sy,
                             output longint cx, cy, fx, fy);
      longint px, py, gw, gh;
      px = longint'(sx) * longint'(scale_x_reg);
      py = longint'(sy) * longint'(scale_y_reg);
      cx = px >>> FRAC;
      cy = py >>> FRAC;
      fx = px & (UNIT - 1);
      fy = py & (UNIT - 1);
      gw = (width_reg > GRID_W) ? GRID_W : width_reg;
      gh = (height_reg > GRID_H_MAX_DFLT) ? GRID_H_MAX_DFLT : height_reg;
      return (cx + 1 < gw) && (cy + 1 < gh);
    endfunction

    function noise_res_t predict_noise(noise_req_t r);
      noise_res_t res;
      longint cx, cy, fx, fy, u, v, d00, d01, d10, d11, n;
      int base;
      res.value = '0;
      res.flag  = 1'b0;
      if (r.kind == REQ_WRITE) begin
        grad_mem[int'(r.row) * GRID_W + int'(r.col)] = {r.gy, r.gx};
        return res;
      end
      if (!locate_cell(r.sx, r.sy, cx, cy, fx, fy)) begin
        res.flag = 1'b1;
        return res;
      end
      u = fade(fx);
      v = fade(fy);
      base = int'(cy) * GRID_W + int'(cx);
      d00 = corner_dot(grad_mem[base], fx, fy);
      d01 = corner_dot(grad_mem[base + GRID_W], fx, fy - UNIT);
      d10 = corner_dot(grad_mem[base + 1], fx - UNIT, fy);
      d11 = corner_dot(grad_mem[base + GRID_W + 1], fx - UNIT, fy - UNIT);
      n = lerp(u, lerp(v, d00, d01), lerp(v, d10, d11));
      if (n > NOISE_MAX) n = NOISE_MAX;
      if (n < NOISE_MIN) n = NOISE_MIN;
      res.value = n[NOISE_W-1:0];
      return res;
    endfunction

    function void note_request(noise_req_t r);
      pending_noise.push_back(predict_noise(r));
    endfunction

    function void check_noise(logic signed [NOISE_W-1:0] value, logic flag);
      noise_res_t exp_res;
      if (pending_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: value %0d out_of_range %0b", value, flag);
        return;
      end
      exp_res = pending_noise.pop_front();
      if (value !== exp_res.value || flag !== exp_res.flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %0d flag %0b, got value %0d flag %0b",
                   exp_res.value, exp_res.flag, value, flag);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        req_type = REQ_WRITE;
  logic [CELL_IDX_W-1:0]       grid_col = '0;
  logic [CELL_IDX_W-1:0]       grid_row = '0;
  logic signed [GRAD_W-1:0]    grad_x = '0;
  logic signed [GRAD_W-1:0]    grad_y = '0;
  logic [COORD_BITS_DFLT-1:0]  sample_x = '0;
  logic [COORD_BITS_DFLT-1:0]  sample_y = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [NOISE_W-1:0]   noise_value;
  logic                        out_of_range;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit written [GRID_CELLS];
  int beats_sent = 0;

  noise_checker sb;

  perlin_gradient_noise_2d_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .grid_col     (grid_col),
    .grid_row     (grid_row),
    .grad_x       (grad_x),
    .grad_y       (grad_y),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .noise_value  (noise_value),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : beat_monitor
    noise_req_t seen;
    if (!rst && in_valid && !in_stall) begin
      seen.kind = req_type_t'(req_type);
      seen.col  = grid_col;
      seen.row  = grid_row;
      seen.gx   = grad_x;
      seen.gy   = grad_y;
      seen.sx   = sample_x;
      seen.sy   = sample_y;
      sb.note_request(seen);
    end
    if (!rst && out_valid && !out_stall)
      sb.check_noise(noise_value, out_of_range);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin : result_sink
    int busy;
    busy = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        busy = HOLD_CYCLES;
      end else if (busy == 0 && !calm && $urandom_range(0, 9) == 0) begin
        busy = $urandom_range(1, 15);
      end
      out_stall <= (busy > 0);
      if (busy > 0) busy--;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("perlin_gradient_noise_2d_core regression: fail");
        $finish;
      end
    end
  end

  function automatic logic signed [GRAD_W-1:0] rand_grad();
    case ($urandom_range(0, 9))
      0:       return NOISE_MAX;
      1:       return NOISE_MIN;
      2:       return '0;
      3:       return GRAD_W'($urandom);
      default: return GRAD_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return SIZE_W'(2);
      1:       return GRID_SIZE_RST;
      2:       return SIZE_W'($urandom_range(65, 127));
      3:       return SIZE_W'($urandom_range(0, 1));
      default: return SIZE_W'($urandom_range(3, 63));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return SCALE_RST;
      1:       return '0;
      2:       return '1;
      3:       return SCALE_W'($urandom_range(1, 255));
      4:       return SCALE_W'($urandom_range(24'h001000, 24'h03FFFF));
      default: return SCALE_W'($urandom_range(24'h002000, 24'h020000));
    endcase
  endfunction

  // largest sample that still lands near the used grid
  function automatic int sample_span(logic [SIZE_W-1:0] size, logic [SCALE_W-1:0] scale);
    longint gs, s;
    gs = (size > GRID_W) ? GRID_W : size;
    if (scale == 0) return 65535;
    s = (gs * UNIT) / longint'(scale);
    return (s > 65535) ? 65535 : int'(s);
  endfunction

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic push_beat(input noise_req_t r);
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= r.kind;
    grid_col <= r.col;
    grid_row <= r.row;
    grad_x   <= r.gx;
    grad_y   <= r.gy;
    sample_x <= r.sx;
    sample_y <= r.sy;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (!calm && $urandom_range(0, 5) == 0)
      pause_sender($urandom_range(1, 15));
  endtask

  task automatic write_gradient(input logic [CELL_IDX_W-1:0] col, row,
                                input logic signed [GRAD_W-1:0] gx, gy);
    noise_req_t r;
    r.kind = REQ_WRITE;
    r.col  = col;
    r.row  = row;
    r.gx   = gx;
    r.gy   = gy;
    r.sx   = COORD_BITS_DFLT'($urandom);
    r.sy   = COORD_BITS_DFLT'($urandom);
    written[int'(row) * GRID_W + int'(col)] = 1'b1;
    push_beat(r);
  endtask

  // fills any unwritten corner of the sampled cell before the sample itself
  task automatic eval_sample(input logic [COORD_BITS_DFLT-1:0] sx, sy);
    noise_req_t r;
    longint cx, cy, fx, fy;
    int addr;
    if (sb.locate_cell(sx, sy, cx, cy, fx, fy)) begin
      for (int k = 0; k < 4; k++) begin
        addr = int'(cy + k / 2) * GRID_W + int'(cx + k % 2);
        if (!written[addr])
          write_gradient(CELL_IDX_W'(cx + k % 2), CELL_IDX_W'(cy + k / 2),
                         rand_grad(), rand_grad());
      end
    end
    r.kind = REQ_EVAL;
    r.col  = CELL_IDX_W'($urandom);
    r.row  = CELL_IDX_W'($urandom);
    r.gx   = GRAD_W'($urandom);
    r.gy   = GRAD_W'($urandom);
    r.sx   = sx;
    r.sy   = sy;
    push_beat(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits above the size field carry junk
  task automatic configure(input logic [SIZE_W-1:0] gw, gh,
                           input logic [SCALE_W-1:0] sxs, sys);
    wait_idle();
    write_reg(CFG_GRID_WIDTH, {(CFG_DATA_W - SIZE_W)'($urandom), gw});
    write_reg(CFG_GRID_HEIGHT, {(CFG_DATA_W - SIZE_W)'($urandom), gh});
    write_reg(CFG_SCALE_X, sxs);
    write_reg(CFG_SCALE_Y, sys);
  endtask

  // count is in input beats, corner fills included
  task automatic run_phase(input int count);
    int span_x, span_y;
    int start;
    span_x = sample_span(sb.width_reg, sb.scale_x_reg);
    span_y = sample_span(sb.height_reg, sb.scale_y_reg);
    start = beats_sent;
    while (beats_sent - start < count) begin
      if ($urandom_range(0, 99) < 30)
        write_gradient(CELL_IDX_W'($urandom), CELL_IDX_W'($urandom), rand_grad(), rand_grad());
      else if ($urandom_range(0, 4) == 0)
        eval_sample(COORD_BITS_DFLT'($urandom), COORD_BITS_DFLT'($urandom));
      else
        eval_sample(COORD_BITS_DFLT'($urandom_range(0, span_x)),
                    COORD_BITS_DFLT'($urandom_range(0, span_y)));
    end
  endtask

  initial begin : main
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: unit scale, full grid
    write_gradient(0, 0, NOISE_MAX, NOISE_MIN);
    write_gradient(1, 0, NOISE_MIN, NOISE_MAX);
    write_gradient(0, 1, 16'sh7FFF, 16'sh8000);
    write_gradient(1, 1, 16'sh0000, 16'sh0000);
    write_gradient(63, 63, 16'sh8000, 16'sh7FFF);
    eval_sample(0, 0);
    eval_sample(62, 62);
    eval_sample(63, 0);
    eval_sample(0, 63);
    eval_sample(16'hFFFF, 16'hFFFF);

    // smallest grid that has an in-range cell, fraction near one and one half
    configure(2, 2, 24'h00FFFF, 24'h008000);
    eval_sample(1, 1);
    eval_sample(0, 0);
    eval_sample(1, 0);
    eval_sample(0, 1);
    eval_sample(16'hFFFF, 0);

    // oversized width, zero height, zero and full scale
    configure(127, 0, 0, 24'hFFFFFF);
    write_reg(CFG_SPARE_IDX, 24'($urandom));
    eval_sample(0, 0);
    eval_sample(16'hFFFF, 16'hFFFF);

    configure(GRID_SIZE_RST, GRID_SIZE_RST, 24'hFFFFFF, 0);
    eval_sample(0, 16'hFFFF);
    eval_sample(1, 0);

    configure(1, GRID_SIZE_RST, SCALE_RST, SCALE_RST);
    eval_sample(0, 0);

    for (int ph = 0; ph < 11; ph++) begin
      configure(pick_size(), pick_size(), pick_scale(), pick_scale());
      if (ph == 2) hold_req = 1'b1;
      run_phase(110);
    end

    // no idling on either side from here on
    calm = 1'b1;
    configure(GRID_SIZE_RST, GRID_SIZE_RST, pick_scale(), pick_scale());
    run_phase(150);
    wait_idle();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_noise.size() == 0)
      $display("perlin_gradient_noise_2d_core regression: pass");
    else
      $display("perlin_gradient_noise_2d_core regression: fail");
    $finish;
  end

endmodule
